### hdl/habs_pkg.sv
package habs_pkg;

  localparam int BUF_DEPTH = 1024;
  localparam int CntW      = $clog2(BUF_DEPTH + 1);
  localparam int IdxW      = 10;
  localparam int NameLen   = 14;
  localparam int SchemeLen = 5;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  typedef enum logic [3:0] {
    PH_SKIP   = 4'd0,
    PH_CR     = 4'd1,
    PH_LINE   = 4'd2,
    PH_NAME   = 4'd3,
    PH_SP1    = 4'd4,
    PH_SCHEME = 4'd5,
    PH_SP2    = 4'd6,
    PH_TOKEN  = 4'd7,
    PH_DONE   = 4'd8,
    PH_NONE   = 4'd9
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic              finished;
    logic              char_valid;
    logic [7:0]        token_char;
    logic [IdxW-1:0]   char_index;
    logic              overflow;
  } result_t;

  function automatic logic [7:0] name_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0:    c = "A";
      4'd1:    c = "U";
      4'd2:    c = "T";
      4'd3:    c = "H";
      4'd4:    c = "O";
      4'd5:    c = "R";
      4'd6:    c = "I";
      4'd7:    c = "Z";
      4'd8:    c = "A";
      4'd9:    c = "T";
      4'd10:   c = "I";
      4'd11:   c = "O";
      4'd12:   c = "N";
      4'd13:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] scheme_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0:    c = "B";
      4'd1:    c = "A";
      4'd2:    c = "S";
      4'd3:    c = "I";
      4'd4:    c = "C";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    logic [7:0] u;
    u = b;
    if (b >= 8'h61 && b <= 8'h7a) begin
      u = b - 8'd32;
    end
    return u;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == ChSpace) || (b >= ChTab && b <= ChCr);
  endfunction

endpackage

### hdl/habs_parser.sv
module habs_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_in,
  output habs_pkg::result_t res
);
  import habs_pkg::*;

  phase_t           phase, phase_next;
  logic [3:0]       match_count, match_count_next;
  logic [CntW-1:0]  token_count, token_count_next;
  logic             overflow_flag, overflow_flag_next;

  logic [7:0]       u;
  logic             cap_req;
  logic             cap;
  logic [CntW-1:0]  count_base;

  always_comb begin
    u                = to_upper(byte_in);
    phase_next       = phase;
    match_count_next = match_count;
    cap_req          = 1'b0;
    count_base       = token_count;
    unique case (phase)
      PH_CR: begin
        if (byte_in == ChLf) begin
          phase_next = PH_LINE;
        end
      end
      PH_LINE: begin
        if (u == name_char(4'd0)) begin
          phase_next       = PH_NAME;
          match_count_next = 4'd1;
        end else if (byte_in == ChCr) begin
          phase_next = PH_CR;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_NAME: begin
        if (match_count < 4'(NameLen) && u == name_char(match_count)) begin
          match_count_next = match_count + 4'd1;
          if (match_count_next == 4'(NameLen)) begin
            phase_next = PH_SP1;
          end
        end else begin
          phase_next = (byte_in == ChCr) ? PH_CR : PH_SKIP;
        end
      end
      PH_SP1: begin
        if (!is_ws(byte_in)) begin
          if (u == scheme_char(4'd0)) begin
            phase_next       = PH_SCHEME;
            match_count_next = 4'd1;
          end else begin
            phase_next = PH_NONE;
          end
        end
      end
      PH_SCHEME: begin
        if (match_count < 4'(SchemeLen) && u == scheme_char(match_count)) begin
          match_count_next = match_count + 4'd1;
          if (match_count_next == 4'(SchemeLen)) begin
            phase_next = PH_SP2;
          end
        end else begin
          phase_next = PH_NONE;
        end
      end
      PH_SP2: begin
        if (!is_ws(byte_in)) begin
          phase_next = PH_TOKEN;
          count_base = '0;
          cap_req    = 1'b1;
        end
      end
      PH_TOKEN: begin
        if (is_ws(byte_in)) begin
          phase_next = PH_DONE;
        end else begin
          cap_req = 1'b1;
        end
      end
      PH_DONE, PH_NONE: begin
      end
      default: begin
        phase_next = (byte_in == ChCr) ? PH_CR : PH_SKIP;
      end
    endcase

    token_count_next   = count_base;
    overflow_flag_next = overflow_flag;
    cap                = 1'b0;
    if (cap_req) begin
      if (count_base < CntW'(BUF_DEPTH)) begin
        cap              = 1'b1;
        token_count_next = count_base + CntW'(1);
      end else begin
        overflow_flag_next = 1'b1;
      end
    end

    res.phase      = phase_next;
    res.finished   = (phase_next == PH_DONE) || (phase_next == PH_NONE);
    res.char_valid = cap;
    res.token_char = cap ? byte_in : 8'h00;
    res.char_index = cap ? count_base[IdxW-1:0] : '0;
    res.overflow   = overflow_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SKIP;
      match_count   <= '0;
      token_count   <= '0;
      overflow_flag <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      match_count   <= match_count_next;
      token_count   <= token_count_next;
      overflow_flag <= overflow_flag_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |=> phase == PH_DONE)
    else $error("done phase left");
  a_none_holds: assert property (@(posedge clk) disable iff (rst)
    phase == PH_NONE |=> phase == PH_NONE)
    else $error("no-credential phase left");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |=> overflow_flag)
    else $error("overflow flag cleared");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    token_count <= CntW'(BUF_DEPTH))
    else $error("token count beyond buffer depth");
`endif

endmodule

### hdl/http_basic_auth_sniffer.sv
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// input    | in_valid / in_ready  | byte_in
// output   | out_valid / out_ready| phase, finished, char_valid, token_char,
//          |                      | char_index, overflow
//
// one byte per cycle while in_ready; result is in the output register next cycle
// parse state updates in the same cycle as the input transfer
// in_ready is high while the output register is empty or being drained
// reset clears the parse state to skipping the request line, output empty
module http_basic_auth_sniffer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  byte_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [3:0]                  phase,
  output logic                        finished,
  output logic                        char_valid,
  output logic [7:0]                  token_char,
  output logic [habs_pkg::IdxW-1:0]   char_index,
  output logic                        overflow
);
  import habs_pkg::*;

  result_t res;
  result_t res_reg;
  logic    step;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  habs_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (byte_in),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (step) begin
      res_reg <= res;
    end
  end

  assign phase      = res_reg.phase;
  assign finished   = res_reg.finished;
  assign char_valid = res_reg.char_valid;
  assign token_char = res_reg.token_char;
  assign char_index = res_reg.char_index;
  assign overflow   = res_reg.overflow;

`ifndef ASSERT_OFF
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output register");
  a_char_in_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid |-> phase == PH_TOKEN)
    else $error("character transfer outside token phase");
  a_finished_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> finished == (phase == PH_DONE || phase == PH_NONE))
    else $error("finished flag disagrees with phase");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import habs_pkg::*;

  class cred_tracker;
    string       hdr = "AUTHORIZATION:";
    string       scheme = "BASIC";
    phase_t      ph;
    int unsigned matched;
    int unsigned tok_len;
    bit          ovf;
    result_t     owed_results[$];
    int          errors;
    int          chars_seen;

    function new();
      ph = PH_SKIP;
      matched = 0;
      tok_len = 0;
      ovf = 0;
      errors = 0;
      chars_seen = 0;
    endfunction

    function logic [7:0] upcase(input logic [7:0] b);
      return (b >= "a" && b <= "z") ? b - 8'd32 : b;
    endfunction

    function bit blank(input logic [7:0] b);
      return b == ChSpace || (b >= ChTab && b <= ChCr);
    endfunction

    // next parse state and captured character for one accepted byte
    function void take_byte(input logic [7:0] b);
      logic [7:0]  u;
      bit          grab;
      int unsigned pos;
      result_t     r;
      u = upcase(b);
      grab = 0;
      pos = 0;
      case (ph)
        PH_CR: begin
          if (b == ChLf) ph = PH_LINE;
        end
        PH_LINE: begin
          if (u == hdr[0]) begin
            ph = PH_NAME;
            matched = 1;
          end else begin
            ph = (b == ChCr) ? PH_CR : PH_SKIP;
          end
        end
        PH_NAME: begin
          if (matched < hdr.len() && u == hdr[matched]) begin
            matched++;
            if (matched == hdr.len()) ph = PH_SP1;
          end else begin
            ph = (b == ChCr) ? PH_CR : PH_SKIP;
          end
        end
        PH_SP1: begin
          if (!blank(b)) begin
            if (u == scheme[0]) begin
              ph = PH_SCHEME;
              matched = 1;
            end else begin
              ph = PH_NONE;
            end
          end
        end
        PH_SCHEME: begin
          if (matched < scheme.len() && u == scheme[matched]) begin
            matched++;
            if (matched == scheme.len()) ph = PH_SP2;
          end else begin
            ph = PH_NONE;
          end
        end
        PH_SP2: begin
          if (!blank(b)) begin
            ph = PH_TOKEN;
            tok_len = 0;
            grab = 1;
          end
        end
        PH_TOKEN: begin
          if (blank(b)) ph = PH_DONE;
          else grab = 1;
        end
        PH_DONE, PH_NONE: begin
        end
        default: begin
          ph = (b == ChCr) ? PH_CR : PH_SKIP;
        end
      endcase
      if (grab) begin
        if (tok_len < BUF_DEPTH) begin
          pos = tok_len;
          tok_len++;
          chars_seen++;
        end else begin
          grab = 0;
          ovf = 1;
        end
      end
      r.phase      = ph;
      r.finished   = (ph == PH_DONE || ph == PH_NONE);
      r.char_valid = grab;
      r.token_char = grab ? b : 8'h00;
      r.char_index = grab ? pos[IdxW-1:0] : '0;
      r.overflow   = ovf;
      owed_results.push_back(r);
    endfunction

    function void diff(input string field, input logic [15:0] exp, input logic [15:0] act);
      if (act !== exp) begin
        $error("%s: expected %0h, got %0h", field, exp, act);
        errors++;
      end
    endfunction

    function void check_result(input result_t got);
      result_t exp;
      if (owed_results.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      exp = owed_results.pop_front();
      diff("phase", 16'(exp.phase), 16'(got.phase));
      diff("finished", 16'(exp.finished), 16'(got.finished));
      diff("char_valid", 16'(exp.char_valid), 16'(got.char_valid));
      diff("token_char", 16'(exp.token_char), 16'(got.token_char));
      diff("char_index", 16'(exp.char_index), 16'(got.char_index));
      diff("overflow", 16'(exp.overflow), 16'(got.overflow));
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  logic [7:0]      byte_in;
  logic            out_valid;
  logic            out_ready;
  logic [3:0]      phase;
  logic            finished;
  logic            char_valid;
  logic [7:0]      token_char;
  logic [IdxW-1:0] char_index;
  logic            overflow;

  cred_tracker sb = new();
  int          bytes_sent = 0;
  bit          in_calm = 0;
  bit          out_calm = 0;

  http_basic_auth_sniffer i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .phase      (phase),
    .finished   (finished),
    .char_valid (char_valid),
    .token_char (token_char),
    .char_index (char_index),
    .overflow   (overflow)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit mix);
    logic [7:0] b;
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      if (mix && (b | 8'h20) >= "a" && (b | 8'h20) <= "z" && $urandom_range(0, 1))
        b = b ^ 8'h20;
      send_byte(b);
    end
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] any_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? ChSpace : ChTab + 8'(k);
  endfunction

  function automatic logic [7:0] solid_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (sb.blank(b));
    return b;
  endfunction

  // any byte that is not the given letter in either case
  function automatic logic [7:0] wrong_for(input logic [7:0] want);
    logic [7:0] b;
    if ($urandom_range(0, 2) == 0) return ChCr;
    do b = 8'($urandom_range(0, 255)); while (sb.upcase(b) == want);
    return b;
  endfunction

  task automatic send_header_line();
    int k;
    case ($urandom_range(0, 3))
      0: send_noise($urandom_range(0, 20));
      1: begin
        k = $urandom_range(1, 13);
        send_text(sb.hdr.substr(0, k - 1), 1);
        send_byte(wrong_for(sb.hdr[k]));
        send_noise($urandom_range(0, 8));
      end
      2: begin
        send_text("Host: ", 1);
        repeat ($urandom_range(3, 15)) send_byte(8'($urandom_range(8'h21, 8'h7e)));
      end
      default: begin
      end
    endcase
    send_byte(ChCr);
    send_byte(ChLf);
  endtask

  initial begin
    logic [7:0] opening[$];
    int         k;
    bit         refuse;
    rst       = 1'b1;
    in_valid  = 1'b0;
    byte_in   = 8'h00;
    out_ready = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // request line, stray byte after CR, empty line, broken names
    opening = '{8'h00, 8'hff, "G", ChCr, "x", ChLf, ChCr, ChLf, "a", "U", "t", ChCr,
                ChLf, "Z", 8'h80, ChCr, ChLf, "A", "x", 8'h7f, ChCr, ChLf};
    foreach (opening[i]) send_byte(opening[i]);

    while (bytes_sent < 800) send_header_line();

    send_text("Authorization:", 1);
    repeat ($urandom_range(0, 3)) send_byte(any_blank());
    refuse = ($urandom_range(0, 3) == 0);
    if (refuse) begin
      if ($urandom_range(0, 1)) begin
        do send_byte(solid_byte()); while (sb.ph == PH_SP1 || sb.ph == PH_SCHEME);
      end else begin
        k = $urandom_range(1, 4);
        send_text(sb.scheme.substr(0, k - 1), 1);
        send_byte(wrong_for(sb.scheme[k]));
      end
    end else begin
      send_text("Basic", 1);
      repeat ($urandom_range(0, 3)) send_byte(any_blank());
      k = ($urandom_range(0, 4) == 0) ? BUF_DEPTH : $urandom_range(BUF_DEPTH + 1, 1090);
      repeat (k) send_byte(solid_byte());
      send_byte(any_blank());
    end
    send_noise($urandom_range(40, 80));
    while (bytes_sent < 1950) send_noise(1);
    in_valid <= 1'b0;

    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("streamed %0d bytes, %0d credential characters captured", bytes_sent,
             sb.chars_seen);
    $display("parse ended in %s, token overflow %0b", sb.ph.name(), sb.ovf);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    result_t got;
    int      gap;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
      gap = out_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.phase      = phase_t'(phase);
      got.finished   = finished;
      got.char_valid = char_valid;
      got.token_char = token_char;
      got.char_index = char_index;
      got.overflow   = overflow;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  initial begin
    #4_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

### files.f
hdl/habs_pkg.sv
hdl/habs_parser.sv
hdl/http_basic_auth_sniffer.sv
test/tb.sv
